FILE: rtl/core/ubxfr_pkg.sv
`timescale 1ns / 1ps

package ubxfr_pkg;

  // Sync pair that opens every frame
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Configuration register map
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_ID_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_ID_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_ID_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_ID_D = 3'd3;

  localparam logic [15:0] RST_ACCEPT_ID_A = 16'h0215;
  localparam logic [15:0] RST_ACCEPT_ID_B = 16'h0213;
  localparam logic [15:0] RST_ACCEPT_ID_C = 16'h0122;
  localparam logic [15:0] RST_ACCEPT_ID_D = 16'h0101;

  // Kinds of result beat
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // One result beat as it travels from the parser to the output buffer
  typedef struct packed {
    logic        item_kind;
    logic [15:0] message_id;
    logic [15:0] byte_index;
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
    logic        checksum_good;
  } result_t;

endpackage

FILE: rtl/core/ubxfr_id_filter.sv
`timescale 1ns / 1ps

module ubxfr_id_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [ubxfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ubxfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [15:0]                     frame_id,
  output logic                            id_hit
);
  import ubxfr_pkg::*;

  logic [15:0] id_a_r;
  logic [15:0] id_b_r;
  logic [15:0] id_c_r;
  logic [15:0] id_d_r;

  // Accepted message IDs; writes beyond the map are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_a_r <= RST_ACCEPT_ID_A;
      id_b_r <= RST_ACCEPT_ID_B;
      id_c_r <= RST_ACCEPT_ID_C;
      id_d_r <= RST_ACCEPT_ID_D;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ACCEPT_ID_A: id_a_r <= cfg_wdata;
        CFG_ACCEPT_ID_B: id_b_r <= cfg_wdata;
        CFG_ACCEPT_ID_C: id_c_r <= cfg_wdata;
        CFG_ACCEPT_ID_D: id_d_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Match the current frame's class and ID against all four entries.
  assign id_hit = (frame_id == id_a_r) || (frame_id == id_b_r) ||
                  (frame_id == id_c_r) || (frame_id == id_d_r);

endmodule

FILE: rtl/core/ubxfr_parser.sv
`timescale 1ns / 1ps

module ubxfr_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_valid,
  input  logic [7:0]          rx_byte,
  input  logic                id_hit,
  output logic [15:0]         frame_id,
  output logic                res_valid,
  output ubxfr_pkg::result_t  res
);
  import ubxfr_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] class_id_r, class_id_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  check_a_r, check_a_nxt;
  logic [15:0] count_inc;
  logic [7:0]  sum_a_base;
  logic [7:0]  sum_b_base;
  logic [7:0]  sum_a_add;
  logic [7:0]  sum_b_add;

  assign frame_id  = class_id_r;
  assign count_inc = count_r + 16'd1;

  // Fletcher-8 step; the class byte restarts both sums.
  assign sum_a_base = (phase_r == PH_CLASS) ? 8'd0 : sum_a_r;
  assign sum_b_base = (phase_r == PH_CLASS) ? 8'd0 : sum_b_r;
  assign sum_a_add  = sum_a_base + rx_byte;
  assign sum_b_add  = sum_b_base + sum_a_add;

  // Next state and result for the byte on the input.
  always_comb begin
    phase_nxt    = phase_r;
    class_id_nxt = class_id_r;
    length_nxt   = length_r;
    count_nxt    = count_r;
    sum_a_nxt    = sum_a_r;
    sum_b_nxt    = sum_b_r;
    check_a_nxt  = check_a_r;
    res_valid    = 1'b0;
    res          = '0;
    res.message_id   = class_id_r;
    res.frame_length = length_r;

    unique case (phase_r)
      PH_SYNC2: begin
        phase_nxt = (rx_byte == SYNC_SECOND) ? PH_CLASS : PH_HUNT;
      end
      PH_CLASS: begin
        sum_a_nxt    = sum_a_add;
        sum_b_nxt    = sum_b_add;
        class_id_nxt = {rx_byte, 8'd0};
        phase_nxt    = PH_ID;
      end
      PH_ID: begin
        sum_a_nxt    = sum_a_add;
        sum_b_nxt    = sum_b_add;
        class_id_nxt = {class_id_r[15:8], rx_byte};
        phase_nxt    = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        sum_a_nxt  = sum_a_add;
        sum_b_nxt  = sum_b_add;
        length_nxt = {8'd0, rx_byte};
        phase_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        sum_a_nxt  = sum_a_add;
        sum_b_nxt  = sum_b_add;
        length_nxt = {rx_byte, length_r[7:0]};
        count_nxt  = '0;
        if (!id_hit) begin
          phase_nxt = PH_HUNT;
        end else if ({rx_byte, length_r[7:0]} == 16'd0) begin
          phase_nxt = PH_CK_A;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_a_nxt      = sum_a_add;
        sum_b_nxt      = sum_b_add;
        res_valid      = 1'b1;
        res.item_kind  = KIND_PAYLOAD;
        res.byte_index = count_r;
        res.data_byte  = rx_byte;
        count_nxt      = count_inc;
        if (count_inc == length_r) begin
          phase_nxt = PH_CK_A;
        end
      end
      PH_CK_A: begin
        check_a_nxt = rx_byte;
        phase_nxt   = PH_CK_B;
      end
      PH_CK_B: begin
        res_valid         = 1'b1;
        res.item_kind     = KIND_END;
        res.checksum_good = (check_a_r == sum_a_r) && (rx_byte == sum_b_r);
        phase_nxt         = PH_HUNT;
      end
      default: begin
        // Hunting, and any code outside the map.
        phase_nxt = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
      end
    endcase
  end

  // Frame state advances only on an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      class_id_r <= '0;
      length_r   <= '0;
      count_r    <= '0;
      sum_a_r    <= '0;
      sum_b_r    <= '0;
      check_a_r  <= '0;
    end else if (byte_valid) begin
      phase_r    <= phase_nxt;
      class_id_r <= class_id_nxt;
      length_r   <= length_nxt;
      count_r    <= count_nxt;
      sum_a_r    <= sum_a_nxt;
      sum_b_r    <= sum_b_nxt;
      check_a_r  <= check_a_nxt;
    end
  end

endmodule

FILE: rtl/core/ubxfr_out_buf.sv
`timescale 1ns / 1ps

module ubxfr_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ubxfr_pkg::result_t push_data,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output ubxfr_pkg::result_t out_data
);
  import ubxfr_pkg::*;

  logic    out_valid_r;
  result_t out_data_r;
  logic    skid_valid_r;
  result_t skid_data_r;
  logic    advance;

  assign advance   = !out_valid_r || out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Output register with a skid stage behind it, so a new beat can be
  // taken while the previous result is still waiting.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (advance) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload moves without reset.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (skid_valid_r) begin
        out_data_r  <= skid_data_r;
        skid_data_r <= push_data;
      end else begin
        out_data_r  <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

FILE: rtl/core/ubx_frame_receiver_core.sv
`timescale 1ns / 1ps
// Results: a payload or end-of-frame result is registered in the output
// register, or in the skid register while the output is stalled.
// Throughput: one byte per cycle while the output buffer has space; the frame state update is a single register
// step, and a two-entry output buffer keeps input and output apart.
// Reset: synchronous, active low; the parser returns to sync hunting, the
// output buffer empties and the four accepted IDs take their reset values.

module ubx_frame_receiver_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_item_kind,
  output logic [15:0]                      out_message_id,
  output logic [15:0]                      out_byte_index,
  output logic [7:0]                       out_data_byte,
  output logic [15:0]                      out_frame_length,
  output logic                             out_checksum_good,
  input  logic                             cfg_wr_en,
  input  logic [ubxfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ubxfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ubxfr_pkg::*;

  logic        byte_accept;
  logic        space;
  logic        id_hit;
  logic [15:0] frame_id;
  logic        res_valid;
  result_t     res;
  result_t     out_data;

  assign in_ready    = space;
  assign byte_accept = in_valid && space;

  ubxfr_id_filter u_id_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .frame_id  (frame_id),
    .id_hit    (id_hit)
  );

  ubxfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_accept),
    .rx_byte    (in_rx_byte),
    .id_hit     (id_hit),
    .frame_id   (frame_id),
    .res_valid  (res_valid),
    .res        (res)
  );

  ubxfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (byte_accept && res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Unpack the result beat onto the output ports.
  assign out_item_kind     = out_data.item_kind;
  assign out_message_id    = out_data.message_id;
  assign out_byte_index    = out_data.byte_index;
  assign out_data_byte     = out_data.data_byte;
  assign out_frame_length  = out_data.frame_length;
  assign out_checksum_good = out_data.checksum_good;

endmodule

FILE: bench/ubx_frame_receiver_core_tb.sv
`timescale 1ns / 1ps

module ubx_frame_receiver_core_tb;
  import ubxfr_pkg::*;

  // Parser phases of the bench's own frame tracker.
  typedef enum logic [3:0] {
    FR_HUNT, FR_SYNC2, FR_CLASS, FR_ID, FR_LEN_LO, FR_LEN_HI, FR_PAYLOAD, FR_CK_A, FR_CK_B
  } frame_phase_t;

  // One byte to send; a pinned row carries the beat it must produce.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       pinned;
    result_t    pinned_beat;
  } plan_t;

  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned ALL_BYTES     = 32'hFFFF_FFFF;
  localparam int unsigned CFG_IDX_SPARE = 4;  // first index past the register map
  localparam int unsigned DIRECTED_ROWS = 28;

  localparam plan_t DIRECTED [DIRECTED_ROWS] = '{
    // Noise at the low extreme, then a broken sync: the second 0xB5 is not
    // taken as a fresh first sync byte, so the 0x62 after it is ignored.
    '{8'h00, 1'b0, '0},
    '{SYNC_FIRST, 1'b0, '0},
    '{SYNC_FIRST, 1'b0, '0},
    '{SYNC_SECOND, 1'b0, '0},
    // Empty payload on the fourth reset ID with a good checksum.
    '{SYNC_FIRST, 1'b0, '0},
    '{SYNC_SECOND, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h02, 1'b0, '0},
    '{8'h07, 1'b1, '{KIND_END, 16'h0101, 16'd0, 8'h00, 16'd0, 1'b1}},
    // Two payload bytes on the first reset ID, extreme values, checksum spoilt.
    '{SYNC_FIRST, 1'b0, '0},
    '{SYNC_SECOND, 1'b0, '0},
    '{8'h02, 1'b0, '0},
    '{8'h15, 1'b0, '0},
    '{8'h02, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b1, '{KIND_PAYLOAD, 16'h0215, 16'd0, 8'hFF, 16'd2, 1'b0}},
    '{8'h00, 1'b1, '{KIND_PAYLOAD, 16'h0215, 16'd1, 8'h00, 16'd2, 1'b0}},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_END, 16'h0215, 16'd0, 8'h00, 16'd2, 1'b0}},
    // Unknown ID with the largest length: no beat, back to hunting.
    '{SYNC_FIRST, 1'b0, '0},
    '{SYNC_SECOND, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_rx_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_item_kind;
  logic [15:0]           out_message_id;
  logic [15:0]           out_byte_index;
  logic [7:0]            out_data_byte;
  logic [15:0]           out_frame_length;
  logic                  out_checksum_good;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Frame tracker state and its copy of the accepted IDs.
  frame_phase_t m_phase;
  logic [15:0]  m_id;
  logic [15:0]  m_len;
  logic [15:0]  m_count;
  logic [15:0]  m_sums;  // {sum_b, sum_a}
  logic [7:0]   m_ck_a;
  logic [15:0]  m_acc [4];

  result_t      pending_beats [$];
  plan_t        stim_plan [$];
  plan_t        cur_item = '0;
  int unsigned  mismatches = 0;
  bit           calm = 1'b0;
  bit           hold_req = 1'b0;
  int unsigned  hold_left = 0;
  int unsigned  stall_left = 0;

  ubx_frame_receiver_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_item_kind     (out_item_kind),
    .out_message_id    (out_message_id),
    .out_byte_index    (out_byte_index),
    .out_data_byte     (out_data_byte),
    .out_frame_length  (out_frame_length),
    .out_checksum_good (out_checksum_good),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #6 clk = ~clk;

  // One Fletcher-8 step on a {b, a} pair.
  function automatic logic [15:0] fletcher_step(input logic [15:0] sums, input logic [7:0] v);
    logic [7:0] a;
    a = sums[7:0] + v;
    return {sums[15:8] + a, a};
  endfunction

  function automatic bit id_known(input logic [15:0] id);
    foreach (m_acc[i]) if (m_acc[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  // Gap length: mostly short, now and then long, none while calm.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic reset_tracker();
    m_phase = FR_HUNT;
    m_id    = '0;
    m_len   = '0;
    m_count = '0;
    m_sums  = '0;
    m_ck_a  = '0;
    m_acc   = '{RST_ACCEPT_ID_A, RST_ACCEPT_ID_B, RST_ACCEPT_ID_C, RST_ACCEPT_ID_D};
  endtask

  // Follow one accepted byte through the frame and give the beat it causes.
  task automatic parse_rx_byte(input logic [7:0] b, output bit emits, output result_t beat);
    emits = 1'b0;
    beat  = '0;
    case (m_phase)
      FR_SYNC2: m_phase = (b == SYNC_SECOND) ? FR_CLASS : FR_HUNT;
      FR_CLASS: begin
        m_sums  = fletcher_step(16'h0000, b);
        m_id    = {b, 8'h00};
        m_phase = FR_ID;
      end
      FR_ID: begin
        m_sums    = fletcher_step(m_sums, b);
        m_id[7:0] = b;
        m_phase   = FR_LEN_LO;
      end
      FR_LEN_LO: begin
        m_sums  = fletcher_step(m_sums, b);
        m_len   = {8'h00, b};
        m_phase = FR_LEN_HI;
      end
      FR_LEN_HI: begin
        m_sums      = fletcher_step(m_sums, b);
        m_len[15:8] = b;
        m_count     = '0;
        if (!id_known(m_id)) m_phase = FR_HUNT;
        else if (m_len == 16'd0) m_phase = FR_CK_A;
        else m_phase = FR_PAYLOAD;
      end
      FR_PAYLOAD: begin
        m_sums  = fletcher_step(m_sums, b);
        emits   = 1'b1;
        beat    = '{KIND_PAYLOAD, m_id, m_count, b, m_len, 1'b0};
        m_count = m_count + 16'd1;
        if (m_count == m_len) m_phase = FR_CK_A;
      end
      FR_CK_A: begin
        m_ck_a  = b;
        m_phase = FR_CK_B;
      end
      FR_CK_B: begin
        emits   = 1'b1;
        beat    = '{KIND_END, m_id, 16'd0, 8'h00, m_len,
                    (m_ck_a == m_sums[7:0]) && (b == m_sums[15:8])};
        m_phase = FR_HUNT;
      end
      default: m_phase = (b == SYNC_FIRST) ? FR_SYNC2 : FR_HUNT;
    endcase
  endtask

  task automatic check_beat(input result_t want);
    if (out_item_kind !== want.item_kind) begin
      $error("item_kind: expected %0d, got %0d", want.item_kind, out_item_kind);
      mismatches++;
    end
    if (out_message_id !== want.message_id) begin
      $error("message_id: expected %h, got %h", want.message_id, out_message_id);
      mismatches++;
    end
    if (out_byte_index !== want.byte_index) begin
      $error("byte_index: expected %0d, got %0d", want.byte_index, out_byte_index);
      mismatches++;
    end
    if (out_data_byte !== want.data_byte) begin
      $error("data_byte: expected %h, got %h", want.data_byte, out_data_byte);
      mismatches++;
    end
    if (out_frame_length !== want.frame_length) begin
      $error("frame_length: expected %0d, got %0d", want.frame_length, out_frame_length);
      mismatches++;
    end
    if (out_checksum_good !== want.checksum_good) begin
      $error("checksum_good: expected %0d, got %0d", want.checksum_good, out_checksum_good);
      mismatches++;
    end
  endtask

  // Everything is sampled at the rising edge; a result leaves before the
  // byte accepted at the same edge can add its own.
  always @(posedge clk) begin : scoreboard
    bit      emits;
    result_t beat;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_beats.size() == 0) begin
          $error("result beat with no expectation waiting");
          mismatches++;
        end else begin
          check_beat(pending_beats.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        parse_rx_byte(cur_item.rx_byte, emits, beat);
        if (cur_item.pinned) pending_beats = {pending_beats, cur_item.pinned_beat};
        else if (emits) pending_beats = {pending_beats, beat};
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ACCEPT_ID_A, CFG_ACCEPT_ID_B, CFG_ACCEPT_ID_C, CFG_ACCEPT_ID_D:
            m_acc[cfg_index[1:0]] = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Receiver: random stalls, and one long hold-off when asked for.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (stall_left != 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready  = 1'b1;
      stall_left = idle_len();
    end
  end

  // Called just after a falling edge; returns just after the falling edge
  // that follows acceptance.
  task automatic send_item(input plan_t it);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_item   = it;
    in_rx_byte = it.rx_byte;
    in_valid   = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    plan_t p;
    p         = '0;
    p.rx_byte = b;
    stim_plan = {stim_plan, p};
  endtask

  // Build a frame with its checksum; keep cuts it short after that many bytes.
  task automatic queue_frame(input logic [15:0] id, input logic [15:0] len, input bit spoil,
                             input int unsigned keep);
    logic [7:0]  fb [$];
    logic [15:0] sums;
    sums = '0;
    fb = {fb, SYNC_FIRST};
    fb = {fb, SYNC_SECOND};
    fb = {fb, id[15:8]};
    fb = {fb, id[7:0]};
    fb = {fb, len[7:0]};
    fb = {fb, len[15:8]};
    for (int i = 0; i < len; i++) fb = {fb, 8'($urandom_range(0, 255))};
    for (int i = 2; i < fb.size(); i++) sums = fletcher_step(sums, fb[i]);
    if (spoil) sums ^= 16'h0001 << $urandom_range(0, 15);
    fb = {fb, sums[7:0]};
    fb = {fb, sums[15:8]};
    for (int i = 0; i < fb.size() && i < keep; i++) queue_byte(fb[i]);
  endtask

  // Mostly well-formed frames on accepted IDs, with noise, broken syncs,
  // cut-off frames and frames on unknown IDs mixed in.
  task automatic random_traffic(input int unsigned n);
    int unsigned pick;
    logic [15:0] id;
    logic [7:0]  b;
    while (stim_plan.size() < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        id = m_acc[$urandom_range(0, 3)];
        queue_frame(id, 16'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 8)
                                                        : $urandom_range(9, 40)),
                    $urandom_range(0, 4) == 0, ALL_BYTES);
      end else if (pick < 78) begin
        queue_byte(8'($urandom_range(0, 255)));
      end else if (pick < 86) begin
        b = 8'($urandom_range(0, 255));
        if (b == SYNC_SECOND) b = SYNC_FIRST;
        queue_byte(SYNC_FIRST);
        queue_byte(b);
        if ($urandom_range(0, 1)) queue_byte(SYNC_SECOND);
      end else if (pick < 93) begin
        queue_frame(m_acc[$urandom_range(0, 3)], 16'($urandom_range(1, 20)), 1'b0,
                    $urandom_range(3, 8));
      end else begin
        do id = 16'($urandom_range(0, 16'hFFFF)); while (id_known(id));
        queue_frame(id, 16'($urandom_range(0, 16'hFFFF)), 1'b0, $urandom_range(6, 10));
      end
    end
  endtask

  task automatic send_plan();
    while (stim_plan.size() != 0) send_item(stim_plan.pop_front());
    in_valid = 1'b0;
  endtask

  // Bring the parser back to hunting, then wait for every expected beat.
  task automatic settle();
    int unsigned waited;
    plan_t       filler;
    filler = '0;
    while (m_phase != FR_HUNT) send_item(filler);
    in_valid = 1'b0;
    waited   = 0;
    while (pending_beats.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_beats.size() != 0) begin
      $error("%0d expected beats never arrived", pending_beats.size());
      mismatches += pending_beats.size();
      pending_beats.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin : stimulus
    in_valid   = 1'b0;
    in_rx_byte = '0;
    cfg_wr_en  = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    rst_n      = 1'b0;
    reset_tracker();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows on the reset IDs.
    foreach (DIRECTED[i]) send_item(DIRECTED[i]);
    in_valid = 1'b0;
    settle();

    // Random traffic on the reset IDs, the first stretch without gaps.
    calm = 1'b1;
    random_traffic(30);
    send_plan();
    calm = 1'b0;
    random_traffic(80);
    send_plan();
    settle();

    // Extreme IDs and two random ones.
    write_reg(CFG_ACCEPT_ID_A, 16'h0000);
    write_reg(CFG_ACCEPT_ID_B, 16'hFFFF);
    write_reg(CFG_ACCEPT_ID_C, 16'($urandom_range(0, 16'hFFFF)));
    write_reg(CFG_ACCEPT_ID_D, 16'($urandom_range(0, 16'hFFFF)));
    random_traffic(120);
    send_plan();
    settle();

    // IDs that look like the sync pair; writes past the map must be ignored.
    write_reg(CFG_ACCEPT_ID_A, 16'($urandom_range(0, 16'hFFFF)));
    write_reg(CFG_ACCEPT_ID_B, {SYNC_FIRST, SYNC_SECOND});
    write_reg(CFG_ACCEPT_ID_C, {SYNC_SECOND, SYNC_FIRST});
    write_reg(CFG_ACCEPT_ID_D, 16'hFFFF);
    for (int i = CFG_IDX_SPARE; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), 16'($urandom_range(0, 16'hFFFF)));
    random_traffic(120);
    send_plan();
    settle();

    // A long frame, sent flat out while the receiver holds off at first.
    calm     = 1'b1;
    hold_req = 1'b1;
    queue_frame(16'hFFFF, 16'd40, 1'b0, ALL_BYTES);
    send_plan();
    settle();
    calm = 1'b0;

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin : watchdog
    #400_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
